FILE: rtl/lra_pkg.sv
// Shared types and constants for the linear regression accumulator.
// Used by lra_muldiv and linear_regression_accumulator; depends on nothing.
`timescale 1ns / 1ps

package lra_pkg;

   localparam int NUM_W  = 128;
   localparam int OPB_W  = 64;
   localparam int STEP_W = 8;

   localparam logic [1:0] MODE_ADD   = 2'd0;
   localparam logic [1:0] MODE_CLEAR = 2'd1;
   localparam logic [1:0] MODE_READ  = 2'd2;

   localparam logic [OPB_W-1:0] Q_MAX = {1'b0, {(OPB_W-1){1'b1}}};
   localparam logic [OPB_W-1:0] Q_MIN = {1'b1, {(OPB_W-1){1'b0}}};

   typedef struct packed {
      logic              start;
      logic              div;
      logic              sub;
      logic [STEP_W-1:0] steps;
   } lra_cmd_type;

endpackage

FILE: rtl/lra_muldiv.sv
// Shared bit-serial multiply-accumulate and restoring divide unit.
// Depends on lra_pkg for widths, saturation limits and the command struct.
`timescale 1ns / 1ps

module lra_muldiv (
   input  logic                               clock,
   input  logic                               reset,
   input  lra_pkg::lra_cmd_type               cmd,
   input  logic signed [lra_pkg::NUM_W-1:0]   opa,
   input  logic signed [lra_pkg::OPB_W-1:0]   opb,
   input  logic signed [lra_pkg::NUM_W-1:0]   init,
   output logic                               done,
   output logic [lra_pkg::NUM_W-1:0]          acc,
   output logic [lra_pkg::OPB_W-1:0]          quo
);

   localparam logic [1:0] U_IDLE = 2'd0;
   localparam logic [1:0] U_RUN  = 2'd1;
   localparam logic [1:0] U_FIN  = 2'd2;

   logic [1:0]                  state_ff, state_in;
   logic [lra_pkg::NUM_W-1:0]   acc_ff, acc_in, mag_ff, mag_in;
   logic [lra_pkg::OPB_W-1:0]   mb_ff, mb_in, quo_ff, quo_in;
   logic [lra_pkg::OPB_W:0]     rem_ff, rem_in, rem_sh;
   logic [lra_pkg::OPB_W+1:0]   diff;
   logic [lra_pkg::NUM_W-1:0]   addend, sum;
   logic [lra_pkg::STEP_W-1:0]  cnt_ff, cnt_in;
   logic                        neg_ff, neg_in, div_ff, div_in, done_ff, done_in, ge;

   assign addend = neg_ff ? ~mag_ff : mag_ff;
   assign sum    = acc_ff + addend + lra_pkg::NUM_W'(neg_ff);
   assign rem_sh = {rem_ff[lra_pkg::OPB_W-1:0], mag_ff[lra_pkg::NUM_W-1]};
   assign diff   = {1'b0, rem_sh} - {2'b00, mb_ff};
   assign ge     = ~diff[lra_pkg::OPB_W+1];

   always_comb begin
      state_in = state_ff;
      acc_in   = acc_ff;
      mag_in   = mag_ff;
      mb_in    = mb_ff;
      rem_in   = rem_ff;
      cnt_in   = cnt_ff;
      neg_in   = neg_ff;
      div_in   = div_ff;
      quo_in   = quo_ff;
      done_in  = 1'b0;
      unique case (state_ff)
         U_IDLE: begin
            if (cmd.start) begin
               mag_in   = opa[lra_pkg::NUM_W-1] ? -opa : opa;
               mb_in    = opb[lra_pkg::OPB_W-1] ? -opb : opb;
               div_in   = cmd.div;
               neg_in   = cmd.div ? opa[lra_pkg::NUM_W-1]
                        : (opa[lra_pkg::NUM_W-1] ^ opb[lra_pkg::OPB_W-1] ^ cmd.sub);
               acc_in   = cmd.div ? '0 : init;
               rem_in   = '0;
               cnt_in   = cmd.steps;
               state_in = U_RUN;
            end
         end
         U_RUN: begin
            cnt_in = cnt_ff - 1'b1;
            mag_in = mag_ff << 1;
            if (div_ff) begin
               rem_in = ge ? diff[lra_pkg::OPB_W:0] : rem_sh;
               acc_in = {acc_ff[lra_pkg::NUM_W-2:0], ge};
            end else begin
               mb_in = mb_ff >> 1;
               if (mb_ff[0]) begin
                  acc_in = sum;
               end
            end
            if (cnt_ff == lra_pkg::STEP_W'(1)) begin
               if (div_ff) begin
                  state_in = U_FIN;
               end else begin
                  state_in = U_IDLE;
                  done_in  = 1'b1;
               end
            end
         end
         U_FIN: begin
            if (neg_ff) begin
               if ((|acc_ff[lra_pkg::NUM_W-1:lra_pkg::OPB_W])
                   || (acc_ff[lra_pkg::OPB_W-1:0] > lra_pkg::Q_MIN)) begin
                  quo_in = lra_pkg::Q_MIN;
               end else begin
                  quo_in = -acc_ff[lra_pkg::OPB_W-1:0];
               end
            end else if (|acc_ff[lra_pkg::NUM_W-1:lra_pkg::OPB_W-1]) begin
               quo_in = lra_pkg::Q_MAX;
            end else begin
               quo_in = acc_ff[lra_pkg::OPB_W-1:0];
            end
            done_in  = 1'b1;
            state_in = U_IDLE;
         end
         default: begin
            state_in = U_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= U_IDLE;
         done_ff  <= 1'b0;
      end else begin
         state_ff <= state_in;
         done_ff  <= done_in;
      end
      acc_ff <= acc_in;
      mag_ff <= mag_in;
      mb_ff  <= mb_in;
      rem_ff <= rem_in;
      cnt_ff <= cnt_in;
      neg_ff <= neg_in;
      div_ff <= div_in;
      quo_ff <= quo_in;
   end

   assign done = done_ff;
   assign acc  = acc_ff;
   assign quo  = quo_ff;

endmodule

FILE: rtl/linear_regression_accumulator.sv
// A clear is done in the idle state; a sample add runs two multiply-accumulates and a read
// runs up to six multiply-accumulates and two divides, all on the one shared bit-serial
// multiply and divide unit. One transaction is worked on at a time.
// Reset synchronously clears the count, all sums, the overflow and null flags and the
// response valid flag. Top level; depends on lra_pkg and lra_muldiv.
`timescale 1ns / 1ps

module linear_regression_accumulator #(
   parameter int SAMPLE_BITS = 16,
   parameter int COUNT_BITS  = 16,
   parameter int FRAC_BITS   = 32
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_ready,
   input  logic [1:0]         req_mode,
   input  logic signed [15:0] req_x_sample,
   input  logic signed [15:0] req_y_sample,
   input  logic               req_x_is_null,
   input  logic               req_y_is_null,
   output logic               rsp_valid,
   input  logic               rsp_ready,
   output logic signed [63:0] rsp_slope,
   output logic signed [63:0] rsp_intercept,
   output logic [15:0]        rsp_sample_count,
   output logic               rsp_result_null,
   output logic               rsp_count_overflow
);

   localparam int SX_W  = SAMPLE_BITS + COUNT_BITS + 1;
   localparam int SXX_W = 2 * SAMPLE_BITS + COUNT_BITS - 1;
   localparam int SXY_W = 2 * SAMPLE_BITS + COUNT_BITS;
   localparam int OW    = lra_pkg::OPB_W;
   localparam int NW    = lra_pkg::NUM_W;

   localparam logic [3:0] S_IDLE   = 4'd0;
   localparam logic [3:0] S_ADD_XX = 4'd1;
   localparam logic [3:0] S_ADD_XY = 4'd2;
   localparam logic [3:0] S_P1     = 4'd3;
   localparam logic [3:0] S_P2     = 4'd4;
   localparam logic [3:0] S_P3     = 4'd5;
   localparam logic [3:0] S_P4     = 4'd6;
   localparam logic [3:0] S_DIV1   = 4'd7;
   localparam logic [3:0] S_P5     = 4'd8;
   localparam logic [3:0] S_P6     = 4'd9;
   localparam logic [3:0] S_DIV2   = 4'd10;
   localparam logic [3:0] S_OUT    = 4'd11;

   logic [3:0]                    state_ff, state_in;
   logic                          issued_ff, issued_in;
   logic [COUNT_BITS-1:0]         count_ff, count_in;
   logic signed [SX_W-1:0]        sum_x_ff, sum_x_in, sum_y_ff, sum_y_in;
   logic [SXX_W-1:0]              sxx_ff, sxx_in;
   logic signed [SXY_W-1:0]       sxy_ff, sxy_in;
   logic                          ovf_ff, ovf_in, null_ff, null_in;
   logic signed [SAMPLE_BITS-1:0] x_ff, x_in, y_ff, y_in;
   logic [OW-1:0]                 var_ff, var_in, slope_ff, slope_in;
   logic                          rsp_valid_ff, rsp_valid_in;
   logic [63:0]                   rsp_slope_ff, rsp_slope_in, rsp_icpt_ff, rsp_icpt_in;
   logic [15:0]                   rsp_count_ff, rsp_count_in;
   logic                          rsp_null_ff, rsp_null_in, rsp_ovf_ff, rsp_ovf_in;

   lra_pkg::lra_cmd_type          cmd;
   logic signed [OW-1:0]          a64, b64, x64, y64, sx64, sy64, sxx64, sxy64, cnt64;
   logic signed [NW-1:0]          opa, init;
   logic                          u_done;
   logic [NW-1:0]                 u_acc;
   logic [OW-1:0]                 u_quo;

   assign x64   = {{(OW-SAMPLE_BITS){x_ff[SAMPLE_BITS-1]}}, x_ff};
   assign y64   = {{(OW-SAMPLE_BITS){y_ff[SAMPLE_BITS-1]}}, y_ff};
   assign sx64  = {{(OW-SX_W){sum_x_ff[SX_W-1]}}, sum_x_ff};
   assign sy64  = {{(OW-SX_W){sum_y_ff[SX_W-1]}}, sum_y_ff};
   assign sxx64 = {{(OW-SXX_W){1'b0}}, sxx_ff};
   assign sxy64 = {{(OW-SXY_W){sxy_ff[SXY_W-1]}}, sxy_ff};
   assign cnt64 = {{(OW-COUNT_BITS){1'b0}}, count_ff};

   always_comb begin
      a64  = '0;
      b64  = '0;
      init = '0;
      unique case (state_ff)
         S_ADD_XX: begin a64 = x64;   b64 = x64;
                         init = {{(NW-OW){1'b0}}, sxx64}; end
         S_ADD_XY: begin a64 = x64;   b64 = y64;
                         init = {{(NW-OW){sxy64[OW-1]}}, sxy64}; end
         S_P1:     begin a64 = sxx64; b64 = cnt64; end
         S_P2:     begin a64 = sx64;  b64 = sx64;  init = u_acc; end
         S_P3:     begin a64 = sxy64; b64 = cnt64; end
         S_P4:     begin a64 = sx64;  b64 = sy64;  init = u_acc; end
         S_P5:     begin a64 = sxx64; b64 = sy64;  end
         S_P6:     begin a64 = sxy64; b64 = sx64;  init = u_acc; end
         S_DIV1, S_DIV2: begin b64 = var_ff; end
         default: begin a64 = '0; end
      endcase
      cmd.start = (state_ff != S_IDLE) && (state_ff != S_OUT) && !issued_ff;
      cmd.div   = (state_ff == S_DIV1) || (state_ff == S_DIV2);
      cmd.sub   = (state_ff == S_P2) || (state_ff == S_P4) || (state_ff == S_P6);
      if ((state_ff == S_ADD_XX) || (state_ff == S_ADD_XY)) begin
         cmd.steps = lra_pkg::STEP_W'(SAMPLE_BITS);
      end else if (cmd.div) begin
         cmd.steps = lra_pkg::STEP_W'(NW);
      end else begin
         cmd.steps = lra_pkg::STEP_W'(SXY_W);
      end
      opa = cmd.div ? (u_acc << FRAC_BITS) : {{(NW-OW){a64[OW-1]}}, a64};
   end

   lra_muldiv u_muldiv (
      .clock (clock),
      .reset (reset),
      .cmd   (cmd),
      .opa   (opa),
      .opb   (b64),
      .init  (init),
      .done  (u_done),
      .acc   (u_acc),
      .quo   (u_quo)
   );

   assign req_ready = (state_ff == S_IDLE);

   always_comb begin
      state_in     = state_ff;
      issued_in    = issued_ff | cmd.start;
      count_in     = count_ff;
      sum_x_in     = sum_x_ff;
      sum_y_in     = sum_y_ff;
      sxx_in       = sxx_ff;
      sxy_in       = sxy_ff;
      ovf_in       = ovf_ff;
      null_in      = null_ff;
      x_in         = x_ff;
      y_in         = y_ff;
      var_in       = var_ff;
      slope_in     = slope_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      rsp_slope_in = rsp_slope_ff;
      rsp_icpt_in  = rsp_icpt_ff;
      rsp_count_in = rsp_count_ff;
      rsp_null_in  = rsp_null_ff;
      rsp_ovf_in   = rsp_ovf_ff;
      if (u_done) begin
         issued_in = 1'b0;
      end
      unique case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               case (req_mode)
                  lra_pkg::MODE_ADD: begin
                     if (!req_x_is_null && !req_y_is_null) begin
                        if (&count_ff) begin
                           ovf_in = 1'b1;
                        end else begin
                           x_in     = req_x_sample[SAMPLE_BITS-1:0];
                           y_in     = req_y_sample[SAMPLE_BITS-1:0];
                           sum_x_in = sum_x_ff + SX_W'(signed'(req_x_sample[SAMPLE_BITS-1:0]));
                           sum_y_in = sum_y_ff + SX_W'(signed'(req_y_sample[SAMPLE_BITS-1:0]));
                           count_in = count_ff + 1'b1;
                           state_in = S_ADD_XX;
                        end
                     end
                  end
                  lra_pkg::MODE_CLEAR: begin
                     count_in = '0;
                     sum_x_in = '0;
                     sum_y_in = '0;
                     sxx_in   = '0;
                     sxy_in   = '0;
                     ovf_in   = 1'b0;
                  end
                  lra_pkg::MODE_READ: begin
                     null_in  = 1'b0;
                     state_in = S_P1;
                  end
                  default: begin
                     state_in = S_IDLE;
                  end
               endcase
            end
         end
         S_ADD_XX: if (u_done) begin
            sxx_in   = u_acc[SXX_W-1:0];
            state_in = S_ADD_XY;
         end
         S_ADD_XY: if (u_done) begin
            sxy_in   = u_acc[SXY_W-1:0];
            state_in = S_IDLE;
         end
         S_P1: if (u_done) begin
            state_in = S_P2;
         end
         S_P2: if (u_done) begin
            var_in = u_acc[OW-1:0];
            if ((count_ff == '0) || (u_acc == '0)) begin
               null_in  = 1'b1;
               state_in = S_OUT;
            end else begin
               state_in = S_P3;
            end
         end
         S_P3: if (u_done) begin
            state_in = S_P4;
         end
         S_P4: if (u_done) begin
            state_in = S_DIV1;
         end
         S_DIV1: if (u_done) begin
            slope_in = u_quo;
            state_in = S_P5;
         end
         S_P5: if (u_done) begin
            state_in = S_P6;
         end
         S_P6: if (u_done) begin
            state_in = S_DIV2;
         end
         S_DIV2: if (u_done) begin
            state_in = S_OUT;
         end
         S_OUT: begin
            if (!rsp_valid_ff || rsp_ready) begin
               rsp_valid_in = 1'b1;
               rsp_slope_in = null_ff ? '0 : slope_ff;
               rsp_icpt_in  = null_ff ? '0 : u_quo;
               rsp_count_in = 16'(count_ff);
               rsp_null_in  = null_ff;
               rsp_ovf_in   = ovf_ff;
               state_in     = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         issued_ff    <= 1'b0;
         count_ff     <= '0;
         sum_x_ff     <= '0;
         sum_y_ff     <= '0;
         sxx_ff       <= '0;
         sxy_ff       <= '0;
         ovf_ff       <= 1'b0;
         null_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         issued_ff    <= issued_in;
         count_ff     <= count_in;
         sum_x_ff     <= sum_x_in;
         sum_y_ff     <= sum_y_in;
         sxx_ff       <= sxx_in;
         sxy_ff       <= sxy_in;
         ovf_ff       <= ovf_in;
         null_ff      <= null_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      x_ff         <= x_in;
      y_ff         <= y_in;
      var_ff       <= var_in;
      slope_ff     <= slope_in;
      rsp_slope_ff <= rsp_slope_in;
      rsp_icpt_ff  <= rsp_icpt_in;
      rsp_count_ff <= rsp_count_in;
      rsp_null_ff  <= rsp_null_in;
      rsp_ovf_ff   <= rsp_ovf_in;
   end

   assign rsp_valid          = rsp_valid_ff;
   assign rsp_slope          = rsp_slope_ff;
   assign rsp_intercept      = rsp_icpt_ff;
   assign rsp_sample_count   = rsp_count_ff;
   assign rsp_result_null    = rsp_null_ff;
   assign rsp_count_overflow = rsp_ovf_ff;

   a_rsp_from_out: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(state_ff == S_OUT))
      else $error("Result transaction appeared without a finished read.");

   a_null_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && rsp_null_ff |-> (rsp_slope_ff == '0) && (rsp_icpt_ff == '0))
      else $error("Null result carries a nonzero slope or intercept.");

   a_done_issued: assert property (@(posedge clock) disable iff (reset)
      u_done |-> issued_ff)
      else $error("Arithmetic unit finished an operation that was never issued.");

endmodule
